// ===== rtl/core/hc256_pkg.sv =====
// Package for the HC-256 stream cipher: controller states, input kinds and cipher constants.
// Used by hc256_stream_cipher; no dependencies.
package hc256_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_GEN,
		ST_EMIT
	} hc_state_t;

	// Operation codes carried in the input tuser.
	localparam logic OP_INIT  = 1'b0;
	localparam logic OP_CRYPT = 1'b1;

	localparam int NUM_REGS     = 8;
	localparam int EXPAND_SKIP  = 512;
	localparam int INIT_STEPS   = 4096;
	localparam int STEP_CYCLES  = 10;

	localparam logic [2:0] BYTE_POS_EMPTY = 3'd4;

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		rotr32 = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		sig0 = rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		sig1 = rotr32(x, 17) ^ rotr32(x, 19) ^ (x >> 10);
	endfunction

endpackage

// ===== rtl/core/hc256_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module hc256_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/hc256_stream_cipher.sv =====
// HC-256 stream cipher top level: controller, key expansion and keystream generator.
// Depends on hc256_pkg and hc256_ram.

// An initialize word expands the key and IV registers into the P and Q tables,
// one table word per cycle, then runs 4096 discarded keystream steps. A crypt
// word whose byte comes from the current keystream word is combined with it
// in the emit state; every fourth byte needs a fresh keystream step first.
// The step length is set by the single read port of each table memory: a step
// does five reads of the updated table and five of the other. A crypt word
// before any initialize is passed through with not_keyed set.
module hc256_stream_cipher
	import hc256_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [63:0] cfg_data,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_in
	input  logic        s_axis_tuser,  // [0] operation
	input  logic        s_axis_tlast,  // last_in
	// Output stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] data_out
	output logic        m_axis_tuser,  // [0] not_keyed
	output logic        m_axis_tlast   // last_out
);

	localparam int AW       = $clog2(TABLE_DEPTH);
	localparam int EXP_LAST = EXPAND_SKIP + 2 * TABLE_DEPTH - 1;
	localparam int EW       = $clog2(EXP_LAST + 1);
	localparam int SW       = AW + 1;
	localparam int IW       = $clog2(INIT_STEPS);

	hc_state_t state_q, state_d;

	logic [63:0]   cfg_q [NUM_REGS];
	logic [31:0]   win_q [16];
	logic [EW-1:0] exp_i_q;
	logic [SW-1:0] step_count_q;
	logic [IW-1:0] init_cnt_q;
	logic [3:0]    sub_q;
	logic          init_run_q;
	logic [31:0]   stream_word_q;
	logic [2:0]    byte_pos_q;
	logic          keyed_q;
	logic [7:0]    din_q;
	logic          last_q;
	logic          nk_q;
	logic          out_valid_q;
	logic [7:0]    out_data_q;
	logic          out_last_q;
	logic          out_nk_q;

	logic [31:0] x_q, y_q, tj_q, t10_q, g_q, z_q, acc_q, new_q;

	logic           accept;
	logic           out_free;
	logic           step_done;
	logic           exp_done;
	logic           use_q_tab;
	logic [AW-1:0]  j;
	logic [31:0]    exp_w;
	logic [31:0]    key_w;
	logic [EW-1:0]  exp_off;

	logic [AW-1:0] t_raddr, u_raddr, t_waddr;
	logic          t_we;
	logic [31:0]   t_rd, u_rd;
	logic          p_we, q_we;
	logic [AW-1:0] p_waddr, q_waddr, p_raddr, q_raddr;
	logic [31:0]   p_wdata, q_wdata, p_rd, q_rd;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_nk_q;

	assign step_done = (sub_q == 4'(STEP_CYCLES - 1));
	assign exp_done  = (exp_i_q == EW'(EXP_LAST));
	assign use_q_tab = step_count_q[AW];
	assign j         = step_count_q[AW-1:0];

	// Expansion word: key and IV words first, then the recurrence.
	assign key_w = exp_i_q[0] ? cfg_q[exp_i_q[3:1]][63:32] : cfg_q[exp_i_q[3:1]][31:0];
	assign exp_w = (exp_i_q < EW'(16)) ? key_w :
		sig1(win_q[1]) + win_q[6] + sig0(win_q[14]) + win_q[15] + 32'(exp_i_q);
	assign exp_off = exp_i_q - EW'(EXPAND_SKIP);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (s_axis_tuser == OP_INIT) begin
						state_d = ST_EXPAND;
					end else if (keyed_q && byte_pos_q[2]) begin
						state_d = ST_GEN;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EXPAND: begin
				if (exp_done) begin
					state_d = ST_GEN;
				end
			end
			ST_GEN: begin
				if (step_done) begin
					if (!init_run_q) begin
						state_d = ST_EMIT;
					end else if (init_cnt_q == IW'(INIT_STEPS - 1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Table access schedule for one keystream step (t updated, u looked up).
	always_comb begin
		t_raddr = j;
		u_raddr = '0;
		t_we    = 1'b0;
		t_waddr = j;
		case (sub_q)
			4'd0: t_raddr = j - AW'(3);
			4'd1: t_raddr = j + AW'(1);
			4'd2: t_raddr = j;
			4'd3: begin
				t_raddr = j - AW'(10);
				u_raddr = x_q[AW-1:0] ^ y_q[AW-1:0];
			end
			4'd4: t_raddr = j - AW'(12);
			4'd5: u_raddr = AW'(t_rd[7:0]);
			4'd6: u_raddr = AW'(256) + AW'(z_q[15:8]);
			4'd7: u_raddr = AW'(512) + AW'(z_q[23:16]);
			4'd8: u_raddr = AW'(768) + AW'(z_q[31:24]);
			4'd9: t_we    = (state_q == ST_GEN);
			default: t_raddr = j;
		endcase
	end

	// Map the t and u roles onto the P and Q memories.
	always_comb begin
		p_raddr = use_q_tab ? u_raddr : t_raddr;
		q_raddr = use_q_tab ? t_raddr : u_raddr;
		t_rd    = use_q_tab ? q_rd : p_rd;
		u_rd    = use_q_tab ? p_rd : q_rd;
		if (state_q == ST_EXPAND) begin
			p_we    = (exp_i_q >= EW'(EXPAND_SKIP)) &&
				(exp_i_q < EW'(EXPAND_SKIP + TABLE_DEPTH));
			q_we    = (exp_i_q >= EW'(EXPAND_SKIP + TABLE_DEPTH));
			p_waddr = exp_off[AW-1:0];
			q_waddr = exp_off[AW-1:0];
			p_wdata = exp_w;
			q_wdata = exp_w;
		end else begin
			p_we    = t_we && !use_q_tab;
			q_we    = t_we && use_q_tab;
			p_waddr = t_waddr;
			q_waddr = t_waddr;
			p_wdata = new_q;
			q_wdata = new_q;
		end
	end

	hc256_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_p_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rd)
	);

	hc256_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_q_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rd)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++) begin
				cfg_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_index < 4'(NUM_REGS)) begin
			cfg_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// Expansion window, a shift line with the newest word at the front.
	always_ff @(posedge clk) begin
		if (state_q == ST_EXPAND) begin
			win_q[0] <= exp_w;
			for (int k = 1; k < 16; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	// Step datapath registers.
	always_ff @(posedge clk) begin
		case (sub_q)
			4'd1: x_q   <= t_rd;
			4'd2: y_q   <= t_rd;
			4'd3: tj_q  <= t_rd;
			4'd4: begin
				t10_q <= t_rd;
				g_q   <= (rotr32(x_q, 10) ^ rotr32(y_q, 23)) + u_rd;
			end
			4'd5: begin
				z_q   <= t_rd;
				new_q <= tj_q + t10_q + g_q;
			end
			4'd6: acc_q <= u_rd;
			4'd7: acc_q <= acc_q + u_rd;
			4'd8: acc_q <= acc_q + u_rd;
			default: acc_q <= acc_q;
		endcase
	end

	// Pending input word.
	always_ff @(posedge clk) begin
		if (accept) begin
			din_q  <= s_axis_tdata;
			last_q <= s_axis_tlast;
			nk_q   <= !keyed_q;
		end
	end

	// Controller and cipher state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			exp_i_q       <= '0;
			step_count_q  <= '0;
			init_cnt_q    <= '0;
			sub_q         <= '0;
			init_run_q    <= 1'b0;
			stream_word_q <= '0;
			byte_pos_q    <= BYTE_POS_EMPTY;
			keyed_q       <= 1'b0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
			out_last_q    <= 1'b0;
			out_nk_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			// The emit state loads the output word itself.
			if (out_valid_q && m_axis_tready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					exp_i_q <= '0;
					sub_q   <= '0;
					if (accept) begin
						init_run_q <= (s_axis_tuser == OP_INIT);
					end
				end
				ST_EXPAND: begin
					exp_i_q      <= exp_i_q + EW'(1);
					step_count_q <= '0;
					init_cnt_q   <= '0;
					sub_q        <= '0;
				end
				ST_GEN: begin
					if (step_done) begin
						sub_q         <= '0;
						step_count_q  <= step_count_q + SW'(1);
						stream_word_q <= (acc_q + u_rd) ^ new_q;
						if (init_run_q) begin
							init_cnt_q <= init_cnt_q + IW'(1);
							if (init_cnt_q == IW'(INIT_STEPS - 1)) begin
								keyed_q    <= 1'b1;
								byte_pos_q <= BYTE_POS_EMPTY;
							end
						end else begin
							byte_pos_q <= '0;
						end
					end else begin
						sub_q <= sub_q + 4'd1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= last_q;
						out_nk_q    <= nk_q;
						if (nk_q) begin
							out_data_q <= din_q;
						end else begin
							out_data_q <= din_q ^ stream_word_q[8*byte_pos_q[1:0] +: 8];
							byte_pos_q <= byte_pos_q + 3'd1;
						end
					end
				end
				default: sub_q <= '0;
			endcase
		end
	end

endmodule
